// ----- src/dct_pkg.sv -----
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types and constants for the dual compare timer: request and result
// payloads, command codes, register read codes and configuration bit layout.
// ----------------------------------------------------------------------------
package dct_pkg;

   localparam int unsigned WORD_BITS            = 32;
   localparam int unsigned PRESCALE_BITS_DEFAULT = 8;

   typedef enum logic [2:0] {
      CMD_SYS_TICK   = 3'd0,
      CMD_REF_EDGE   = 3'd1,
      CMD_WR_CONFIG  = 3'd2,
      CMD_WR_COUNT   = 3'd3,
      CMD_WR_COMPARE = 3'd4,
      CMD_RESET      = 3'd5,
      CMD_START      = 3'd6,
      CMD_READ       = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      REG_CONFIG  = 2'd0,
      REG_COUNT   = 2'd1,
      REG_COMPARE = 2'd2
   } reg_index_type;

   // Configuration word bit positions.
   localparam int unsigned CFG_ENABLE    = 0;
   localparam int unsigned CFG_CLR_COUNT = 1;
   localparam int unsigned CFG_IRQ_EN    = 2;
   localparam int unsigned CFG_CLR_MATCH = 4;
   localparam int unsigned CFG_ONE_SHOT  = 5;
   localparam int unsigned CFG_PS_EN     = 6;
   localparam int unsigned CFG_REF_CLK   = 7;
   localparam int unsigned CFG_PS_LSB    = 8;
   localparam int unsigned CFG_CASCADE   = 31;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       sel;
      logic [1:0] reg_index;
      word_type   wdata;
   } req_type;

   typedef struct packed {
      logic     irq_lo;
      logic     irq_hi;
      word_type read_data;
      logic     enabled_lo;
      logic     enabled_hi;
   } rsp_type;

   // Controls from the timer core to one prescaler.
   typedef struct packed {
      logic tick;
      logic clear;
      logic enable;
   } ps_ctrl_type;

endpackage

// ----- src/dct_prescaler.sv -----
// ----------------------------------------------------------------------------
// dct_prescaler
// Divide-by-(limit+1) prescaler for one counter. The fire output is high on
// the tick where the counter should advance.
// ----------------------------------------------------------------------------
module dct_prescaler #(
   parameter int unsigned PRESCALE_BITS = dct_pkg::PRESCALE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dct_pkg::ps_ctrl_type     ctrl,
   input  logic [PRESCALE_BITS-1:0] limit,
   output logic                     fires
);

   logic [PRESCALE_BITS-1:0] count_ff;
   logic [PRESCALE_BITS-1:0] count_in;
   logic                     at_limit;

   assign at_limit = (count_ff == limit);
   assign fires    = !ctrl.enable || at_limit;

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.tick && ctrl.enable) begin
         count_in = at_limit ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- src/dct_core.sv -----
// ----------------------------------------------------------------------------
// dct_core
// Timer state and the single-pass update: counting, register writes, match
// checks with clear, interrupt and one-shot, and register reads.
// ----------------------------------------------------------------------------
module dct_core #(
   parameter int unsigned PRESCALE_BITS = dct_pkg::PRESCALE_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  dct_pkg::req_type item,
   output dct_pkg::rsp_type result
);

   dct_pkg::word_type count_ff   [2];
   dct_pkg::word_type compare_ff [2];
   dct_pkg::word_type config_ff  [2];
   logic              run_ff     [2];

   dct_pkg::word_type count_a    [2];
   dct_pkg::word_type compare_a  [2];
   dct_pkg::word_type config_a   [2];
   logic              run_a      [2];
   dct_pkg::word_type count_in   [2];
   logic              run_in     [2];

   dct_pkg::ps_ctrl_type ps_ctrl [2];
   logic                 ps_fires [2];

   logic              is_tick;
   logic              is_ref;
   logic              is_access;
   logic              cascade;
   logic              cascade_a;
   logic              gate0;
   logic              gate1;
   logic              adv0;
   logic              adv1;
   dct_pkg::word_type lo_inc;
   dct_pkg::word_type hi_inc;
   logic              chk0;
   logic              chk1;
   logic              hit0;
   logic              hit1;
   logic              match0;
   logic              match1;
   dct_pkg::word_type read_value;

   assign is_tick   = (item.cmd == dct_pkg::CMD_SYS_TICK) || (item.cmd == dct_pkg::CMD_REF_EDGE);
   assign is_ref    = (item.cmd == dct_pkg::CMD_REF_EDGE);
   assign is_access = !is_tick && (item.cmd != dct_pkg::CMD_READ);
   assign cascade   = config_ff[0][dct_pkg::CFG_CASCADE];

   // In cascade mode counter one only carries the upper half of counter zero.
   assign gate0 = is_tick && run_ff[0] && (config_ff[0][dct_pkg::CFG_REF_CLK] == is_ref);
   assign gate1 = is_tick && !cascade && run_ff[1]
                  && (config_ff[1][dct_pkg::CFG_REF_CLK] == is_ref);

   for (genvar c = 0; c < 2; c++) begin : g_ps
      assign ps_ctrl[c].tick   = fire && ((c == 0) ? gate0 : gate1);
      assign ps_ctrl[c].clear  = fire && (item.cmd == dct_pkg::CMD_WR_CONFIG)
                                 && (item.sel == 1'(c));
      assign ps_ctrl[c].enable = config_ff[c][dct_pkg::CFG_PS_EN];

      dct_prescaler #(
         .PRESCALE_BITS (PRESCALE_BITS)
      ) u_prescaler (
         .clock (clock),
         .reset (reset),
         .ctrl  (ps_ctrl[c]),
         .limit (config_ff[c][dct_pkg::CFG_PS_LSB +: PRESCALE_BITS]),
         .fires (ps_fires[c])
      );
   end

   assign adv0   = gate0 && ps_fires[0];
   assign adv1   = gate1 && ps_fires[1];
   assign lo_inc = count_ff[0] + 1'b1;
   assign hi_inc = count_ff[1] + 1'b1;

   // State after the tick advance and the command itself, before the match check.
   always_comb begin
      count_a   = count_ff;
      compare_a = compare_ff;
      config_a  = config_ff;
      run_a     = run_ff;
      if (adv0) begin
         count_a[0] = lo_inc;
         if (cascade && (lo_inc == '0)) begin
            count_a[1] = hi_inc;
         end
      end
      if (adv1) begin
         count_a[1] = hi_inc;
      end
      case (item.cmd)
         dct_pkg::CMD_WR_CONFIG: begin
            config_a[item.sel] = item.wdata;
            run_a[item.sel]    = item.wdata[dct_pkg::CFG_ENABLE];
            if (item.wdata[dct_pkg::CFG_CLR_COUNT]) begin
               count_a[item.sel] = '0;
            end
         end
         dct_pkg::CMD_WR_COUNT: begin
            count_a[item.sel] = item.wdata;
         end
         dct_pkg::CMD_WR_COMPARE: begin
            compare_a[item.sel] = item.wdata;
         end
         dct_pkg::CMD_RESET: begin
            count_a[item.sel] = '0;
         end
         dct_pkg::CMD_START: begin
            run_a[item.sel] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign cascade_a = config_a[0][dct_pkg::CFG_CASCADE];
   assign chk0      = adv0 || is_access;
   assign chk1      = adv1 || (is_access && !cascade_a);
   assign hit0      = (count_a[0] == compare_a[0])
                      && (!cascade_a || (count_a[1] == compare_a[1]));
   assign hit1      = (count_a[1] == compare_a[1]);
   assign match0    = chk0 && run_a[0] && hit0;
   assign match1    = chk1 && run_a[1] && hit1;

   always_comb begin
      count_in = count_a;
      run_in   = run_a;
      if (match0 && config_a[0][dct_pkg::CFG_CLR_MATCH]) begin
         count_in[0] = '0;
         if (cascade_a) begin
            count_in[1] = '0;
         end
      end
      if (match1 && config_a[1][dct_pkg::CFG_CLR_MATCH]) begin
         count_in[1] = '0;
      end
      if (match0 && config_a[0][dct_pkg::CFG_ONE_SHOT]) begin
         run_in[0] = 1'b0;
      end
      if (match1 && config_a[1][dct_pkg::CFG_ONE_SHOT]) begin
         run_in[1] = 1'b0;
      end
   end

   always_comb begin
      read_value = '0;
      if (item.cmd == dct_pkg::CMD_READ) begin
         case (item.reg_index)
            dct_pkg::REG_CONFIG:  read_value = config_ff[item.sel];
            dct_pkg::REG_COUNT:   read_value = count_ff[item.sel];
            dct_pkg::REG_COMPARE: read_value = compare_ff[item.sel];
            default:              read_value = '0;
         endcase
      end
   end

   assign result.irq_lo     = match0 && config_a[0][dct_pkg::CFG_IRQ_EN];
   assign result.irq_hi     = match1 && config_a[1][dct_pkg::CFG_IRQ_EN];
   assign result.read_data  = read_value;
   assign result.enabled_lo = run_in[0];
   assign result.enabled_hi = run_in[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            count_ff[c]   <= '0;
            compare_ff[c] <= '0;
            config_ff[c]  <= '0;
            run_ff[c]     <= 1'b0;
         end
      end else if (fire) begin
         count_ff   <= count_in;
         compare_ff <= compare_a;
         config_ff  <= config_a;
         run_ff     <= run_in;
      end
   end

endmodule

// ----- src/dual_compare_timer.sv -----
// ----------------------------------------------------------------------------
// dual_compare_timer
// Two 32-bit compare timers with prescalers, joinable into one 64-bit timer.
// Each request is a clock tick or a bus access and yields exactly one result.
//
//   Channel  Ports                           Direction  Moves
//   req      req_valid/req_stall/req_payload in         tick or bus access
//   rsp      rsp_valid/rsp_stall/rsp_payload out        irq, read data, status
//
// A request is registered on acceptance into the input stage and processed there;
// its result is registered into the output stage as it advances. One request per
// cycle is sustained while the result side does not stall. The timer state
// updates as the result is registered.
// Synchronous reset clears all timer state and both pipeline stages.
// A stalled result holds the input stage once it is full.
// ----------------------------------------------------------------------------
module dual_compare_timer #(
   parameter int unsigned PRESCALE_BITS = dct_pkg::PRESCALE_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dct_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dct_pkg::rsp_type rsp_payload
);

   logic             in_valid_ff;
   dct_pkg::req_type in_item_ff;
   logic             out_valid_ff;
   dct_pkg::rsp_type out_item_ff;
   dct_pkg::rsp_type result;
   logic             advance;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   dct_core #(
      .PRESCALE_BITS (PRESCALE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

// ----- src/dct_checker.sv -----
// ----------------------------------------------------------------------------
// dct_checker
// Port-level checks on the dual compare timer's request and result flow.
// ----------------------------------------------------------------------------
module dct_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dct_pkg::rsp_type rsp_payload
);

   // Once an accepted request has passed the input stage, the result stage holds a result.
   a_req_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("accepted request did not produce a result");

   // Requests are only held off by a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without downstream stall");

   // Both stages come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind dual_compare_timer dct_checker u_dct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- dv/dual_compare_timer_test.sv -----
// ----------------------------------------------------------------------------
// dual_compare_timer_test
// Self-checking testbench for the dual compare timer. Requests are driven
// through the valid/stall channel, and an in-bench model of both counters,
// the prescalers and the cascade mode predicts each result. Results are
// compared field by field in order of acceptance.
// ----------------------------------------------------------------------------
module dual_compare_timer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dct_pkg::*;

   localparam int unsigned PS_BITS    = PRESCALE_BITS_DEFAULT;
   localparam logic [1:0]  REG_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   dual_compare_timer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Timer model state, cleared once to match the single reset.
   word_type           model_count   [2] = '{default: '0};
   word_type           model_compare [2] = '{default: '0};
   word_type           model_config  [2] = '{default: '0};
   logic               running       [2] = '{default: 1'b0};
   logic               irq_on        [2] = '{default: 1'b0};
   logic               clear_on_hit  [2] = '{default: 1'b0};
   logic               single_shot   [2] = '{default: 1'b0};
   logic               divide_on     [2] = '{default: 1'b0};
   logic               on_ref_clock  [2] = '{default: 1'b0};
   logic [PS_BITS-1:0] divide_limit  [2] = '{default: '0};
   logic [PS_BITS-1:0] divide_count  [2] = '{default: '0};
   logic               joined = 1'b0;

   rsp_type     pending_results [$];
   int unsigned fail_count   = 0;
   int unsigned sent_count   = 0;
   bit          send_gaps    = 1'b1;
   bit          stall_bursts = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Compare hit on counter c; returns the interrupt it raises.
   function automatic logic compare_hit(int c);
      logic hit;
      if (!running[c])
         return 1'b0;
      if (joined && c == 0)
         hit = model_count[0] == model_compare[0] && model_count[1] == model_compare[1];
      else
         hit = model_count[c] == model_compare[c];
      if (!hit)
         return 1'b0;
      if (clear_on_hit[c]) begin
         model_count[c] = '0;
         if (joined && c == 0)
            model_count[1] = '0;
      end
      if (single_shot[c])
         running[c] = 1'b0;
      return irq_on[c];
   endfunction

   function automatic rsp_type next_timer_result(req_type r);
      rsp_type  res;
      logic     irq [2];
      logic     fire;
      word_type w;
      int       c;
      res    = '0;
      irq[0] = 1'b0;
      irq[1] = 1'b0;
      case (r.cmd)
         CMD_SYS_TICK, CMD_REF_EDGE: begin
            for (c = 0; c < 2; c++) begin
               if (!(joined && c == 1) && running[c] &&
                   on_ref_clock[c] == (r.cmd == CMD_REF_EDGE)) begin
                  fire = 1'b1;
                  if (divide_on[c]) begin
                     if (divide_count[c] == divide_limit[c]) begin
                        divide_count[c] = '0;
                     end else begin
                        divide_count[c] = divide_count[c] + 1'b1;
                        fire = 1'b0;
                     end
                  end
                  if (fire) begin
                     model_count[c] = model_count[c] + 1'b1;
                     if (joined && c == 0 && model_count[0] == '0)
                        model_count[1] = model_count[1] + 1'b1;
                     irq[c] = compare_hit(c);
                  end
               end
            end
         end
         CMD_READ: begin
            case (r.reg_index)
               REG_CONFIG:  res.read_data = model_config[r.sel];
               REG_COUNT:   res.read_data = model_count[r.sel];
               REG_COMPARE: res.read_data = model_compare[r.sel];
               default:     res.read_data = '0;
            endcase
         end
         default: begin
            case (r.cmd)
               CMD_WR_CONFIG: begin
                  w = r.wdata;
                  model_config[r.sel] = w;
                  running[r.sel]      = w[CFG_ENABLE];
                  irq_on[r.sel]       = w[CFG_IRQ_EN];
                  clear_on_hit[r.sel] = w[CFG_CLR_MATCH];
                  single_shot[r.sel]  = w[CFG_ONE_SHOT];
                  divide_on[r.sel]    = w[CFG_PS_EN];
                  on_ref_clock[r.sel] = w[CFG_REF_CLK];
                  divide_limit[r.sel] = w[CFG_PS_LSB +: PS_BITS];
                  divide_count[r.sel] = '0;
                  if (r.sel == 1'b0)
                     joined = w[CFG_CASCADE];
                  if (w[CFG_CLR_COUNT])
                     model_count[r.sel] = '0;
               end
               CMD_WR_COUNT:   model_count[r.sel] = r.wdata;
               CMD_WR_COMPARE: model_compare[r.sel] = r.wdata;
               CMD_RESET:      model_count[r.sel] = '0;
               CMD_START:      running[r.sel] = 1'b1;
               default: ;
            endcase
            irq[0] = compare_hit(0);
            if (!joined)
               irq[1] = compare_hit(1);
         end
      endcase
      res.irq_lo     = irq[0];
      res.irq_hi     = irq[1];
      res.enabled_lo = running[0];
      res.enabled_hi = running[1];
      return res;
   endfunction

   task automatic log_failure(string text);
      fail_count++;
      if (fail_count <= 10)
         $display("%t: %s", $realtime, text);
   endtask

   function automatic string show_result(rsp_type r);
      return $sformatf("irq_lo=%0b irq_hi=%0b read_data=%h enabled_lo=%0b enabled_hi=%0b",
                       r.irq_lo, r.irq_hi, r.read_data, r.enabled_lo, r.enabled_hi);
   endfunction

   initial begin : result_checker
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               log_failure({"result with no request outstanding: ", show_result(rsp_payload)});
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.irq_lo !== want.irq_lo || rsp_payload.irq_hi !== want.irq_hi ||
                   rsp_payload.read_data !== want.read_data ||
                   rsp_payload.enabled_lo !== want.enabled_lo ||
                   rsp_payload.enabled_hi !== want.enabled_hi)
                  log_failure({"mismatch: expected ", show_result(want),
                               " got ", show_result(rsp_payload)});
            end
         end
      end
   end

   // The result side holds off in short random bursts while enabled.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_bursts && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_req(cmd_type cmd, logic sel, logic [1:0] idx,
                                        word_type wd);
      req_type r;
      r.cmd       = cmd;
      r.sel       = sel;
      r.reg_index = idx;
      r.wdata     = wd;
      return r;
   endfunction

   function automatic req_type random_read();
      return make_req(CMD_READ, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)),
                      $urandom());
   endfunction

   function automatic word_type random_config(logic sel, logic cascade, int unsigned max_limit);
      word_type w;
      w = $urandom();
      w[CFG_ENABLE] = $urandom_range(0, 7) != 0;
      w[CFG_PS_LSB +: PS_BITS] = PS_BITS'($urandom_range(0, max_limit));
      if (sel == 1'b0)
         w[CFG_CASCADE] = cascade;
      return w;
   endfunction

   // Sends one request and records its predicted result on acceptance.
   task automatic send_request(input req_type r);
      @(negedge clock);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(next_timer_result(r));
      sent_count++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Mostly ticks of the given clock, some of the other one, an odd read.
   task automatic send_ticks(int unsigned n, logic on_ref);
      logic use_ref;
      repeat (n) begin
         use_ref = ($urandom_range(0, 4) == 0) ? !on_ref : on_ref;
         send_request(make_req(use_ref ? CMD_REF_EDGE : CMD_SYS_TICK, 1'($urandom_range(0, 1)),
                               2'($urandom_range(0, 3)), $urandom()));
         if ($urandom_range(0, 9) == 0)
            send_request(random_read());
      end
   endtask

   // Configure one counter, park it up to four steps short of its compare value
   // and tick it toward the match.
   task automatic compare_sequence(logic sel, int unsigned max_limit);
      word_type    cfg;
      word_type    target;
      int unsigned lead;
      int unsigned per_step;
      int unsigned ticks;
      cfg  = random_config(sel, 1'b0, max_limit);
      lead = $urandom_range(0, 4);
      case ($urandom_range(0, 5))
         0:       target = '0;
         1:       target = '1;
         default: target = $urandom();
      endcase
      per_step = cfg[CFG_PS_EN] ? cfg[CFG_PS_LSB +: PS_BITS] + 1 : 1;
      ticks    = (lead + 1) * per_step + $urandom_range(0, 2);
      if (ticks > 30)
         ticks = 30;
      send_request(make_req(CMD_WR_CONFIG, sel, 2'($urandom_range(0, 3)), cfg));
      send_request(make_req(CMD_WR_COMPARE, sel, 2'($urandom_range(0, 3)), target));
      send_request(make_req(CMD_WR_COUNT, sel, 2'($urandom_range(0, 3)),
                            target - word_type'(lead)));
      send_ticks(ticks, cfg[CFG_REF_CLK]);
      case ($urandom_range(0, 3))
         0:       send_request(make_req(CMD_START, sel, 2'($urandom_range(0, 3)), $urandom()));
         1:       send_request(make_req(CMD_RESET, sel, 2'($urandom_range(0, 3)), $urandom()));
         default: ;
      endcase
      send_request(make_req(CMD_READ, sel, REG_COUNT, $urandom()));
   endtask

   task automatic test_directed();
      word_type cfg;
      send_request(make_req(CMD_READ, 1'b0, REG_CONFIG, '0));
      send_request(make_req(CMD_READ, 1'b1, REG_COUNT, '1));
      send_request(make_req(CMD_READ, 1'b0, REG_COMPARE, '0));
      send_request(make_req(CMD_READ, 1'b1, REG_UNUSED, '1));
      // Counter zero steps onto an all-ones compare value with interrupt,
      // clear and one-shot set.
      send_request(make_req(CMD_WR_COMPARE, 1'b0, REG_CONFIG, 32'hffff_ffff));
      send_request(make_req(CMD_WR_COUNT, 1'b0, REG_CONFIG, 32'hffff_fffe));
      cfg = '0;
      cfg[CFG_ENABLE]    = 1'b1;
      cfg[CFG_IRQ_EN]    = 1'b1;
      cfg[CFG_CLR_MATCH] = 1'b1;
      cfg[CFG_ONE_SHOT]  = 1'b1;
      send_request(make_req(CMD_WR_CONFIG, 1'b0, REG_CONFIG, cfg));
      send_request(make_req(CMD_SYS_TICK, 1'b0, REG_CONFIG, '0));
      // The one-shot disable must not show in the config readback.
      send_request(make_req(CMD_READ, 1'b0, REG_CONFIG, '0));
      send_request(make_req(CMD_READ, 1'b0, REG_COUNT, '0));
      send_request(make_req(CMD_START, 1'b0, REG_CONFIG, '0));
      // A count write that lands on the compare value matches at once.
      send_request(make_req(CMD_WR_COUNT, 1'b0, REG_CONFIG, 32'hffff_ffff));
      // Counter one on the reference clock, divided by three.
      cfg = '0;
      cfg[CFG_ENABLE]  = 1'b1;
      cfg[CFG_PS_EN]   = 1'b1;
      cfg[CFG_REF_CLK] = 1'b1;
      cfg[CFG_PS_LSB +: PS_BITS] = PS_BITS'(2);
      send_request(make_req(CMD_WR_CONFIG, 1'b1, REG_CONFIG, cfg));
      repeat (3) send_request(make_req(CMD_REF_EDGE, 1'b1, REG_COUNT, '1));
      send_request(make_req(CMD_SYS_TICK, 1'b1, REG_COUNT, '1));
      send_request(make_req(CMD_READ, 1'b1, REG_COUNT, '0));
      // Every bit set: cascade, largest prescale limit, counter one frozen.
      send_request(make_req(CMD_WR_CONFIG, 1'b0, REG_COMPARE, '1));
      send_request(make_req(CMD_RESET, 1'b1, REG_COMPARE, '0));
      send_request(make_req(CMD_REF_EDGE, 1'b0, REG_COMPARE, '0));
      send_request(make_req(CMD_WR_CONFIG, 1'b0, REG_CONFIG, '0));
      send_request(make_req(CMD_WR_CONFIG, 1'b1, REG_CONFIG, '0));
      send_request(make_req(CMD_WR_COMPARE, 1'b1, REG_CONFIG, '0));
   endtask

   task automatic test_compare_sequences();
      while (sent_count < 620)
         compare_sequence(1'($urandom_range(0, 1)), ($urandom_range(0, 14) == 0) ? 255 : 2);
   endtask

   // The 64-bit count crosses the low-half wrap before reaching its match.
   task automatic test_cascade();
      word_type    cfg;
      word_type    hi_target;
      int unsigned lead;
      int unsigned per_step;
      while (sent_count < 850) begin
         cfg       = random_config(1'b0, 1'b1, 1);
         lead      = $urandom_range(1, 5);
         hi_target = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
         per_step  = cfg[CFG_PS_EN] ? cfg[CFG_PS_LSB +: PS_BITS] + 1 : 1;
         send_request(make_req(CMD_WR_CONFIG, 1'b1, 2'($urandom_range(0, 3)),
                               random_config(1'b1, 1'b0, 1)));
         send_request(make_req(CMD_WR_CONFIG, 1'b0, 2'($urandom_range(0, 3)), cfg));
         send_request(make_req(CMD_WR_COMPARE, 1'b1, 2'($urandom_range(0, 3)), hi_target));
         send_request(make_req(CMD_WR_COMPARE, 1'b0, 2'($urandom_range(0, 3)),
                               word_type'(lead - 1)));
         send_request(make_req(CMD_WR_COUNT, 1'b1, 2'($urandom_range(0, 3)),
                               hi_target - 1'b1));
         send_request(make_req(CMD_WR_COUNT, 1'b0, 2'($urandom_range(0, 3)), '1));
         send_ticks(lead * per_step + $urandom_range(0, 2), cfg[CFG_REF_CLK]);
         send_request(make_req(CMD_READ, 1'b1, REG_COUNT, $urandom()));
         if ($urandom_range(0, 2) == 0)
            send_request(make_req(CMD_START, 1'($urandom_range(0, 1)),
                                  2'($urandom_range(0, 3)), $urandom()));
      end
   endtask

   task automatic test_noise();
      cmd_type cmd;
      while (sent_count < 1020) begin
         if ($urandom_range(0, 1) == 0)
            cmd = $urandom_range(0, 1) ? CMD_REF_EDGE : CMD_SYS_TICK;
         else
            cmd = cmd_type'($urandom_range(0, 7));
         send_request(make_req(cmd, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               $urandom()));
      end
   endtask

   task automatic test_back_to_back();
      send_gaps    = 1'b0;
      stall_bursts = 1'b0;
      while (sent_count < 1150)
         compare_sequence(1'($urandom_range(0, 1)), 2);
   endtask

   initial begin
      int unsigned spins;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      drain_results();
      test_compare_sequences();
      drain_results();
      test_cascade();
      drain_results();
      test_noise();
      drain_results();
      test_back_to_back();

      @(negedge clock);
      req_valid <= 1'b0;
      spins = 0;
      while (pending_results.size() != 0 && spins < 2000) begin
         @(posedge clock);
         spins++;
      end
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         log_failure($sformatf("%0d results never arrived", pending_results.size()));
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
